### design/unordered_bag_table_core_macros.svh
// Assertion macros for the unordered bag table core.
// Used by unordered_bag_table_core.sv; expects clk_i and rst_ni in scope.
`ifndef UNORDERED_BAG_TABLE_CORE_MACROS_SVH
`define UNORDERED_BAG_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define UBT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("unordered_bag_table_core: assertion failed");
`define UBT_ASSERT_IMPL(lbl, pre, post) \
  `UBT_ASSERT(lbl, (pre) |-> (post))
`define UBT_ASSERT_NEXT(lbl, pre, post) \
  `UBT_ASSERT(lbl, (pre) |=> (post))
`else
`define UBT_ASSERT(lbl, prop)
`define UBT_ASSERT_IMPL(lbl, pre, post)
`define UBT_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### design/ubt_pkg.sv
// Package for the unordered bag table core: command and status codes,
// field widths and parameter defaults. No dependencies.
package ubt_pkg;

  localparam int UBT_DEPTH      = 16;
  localparam int UBT_VALUE_BITS = 32;

  localparam int CMD_W   = 2;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 5;
  localparam int CNTF_W  = 5;
  localparam int IDXF_W  = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

### design/unordered_bag_table_core.sv
// Unordered bag table core: bounded multiset held in a one-port-read,
// one-port-write entry memory. Depends on ubt_pkg and the assertion macros.
`include "unordered_bag_table_core_macros.svh"

// One transaction at a time: an accepted item scans the occupied slots of the
// entry memory, one synchronous read per cycle, counting matches and noting
// the first one, then adds, removes (reading the last slot and writing it into
// the matched slot), clears or only reports. The next item is accepted only
// after the last item's result has been loaded into the output register.
// The length of the scan is set by the single read port of the entry memory.
// The result sits in an output register, so a waiting result does not hold
// off the next item's scan until that item is finished. The capacity
// register takes a write in any cycle and is meant to be written while the
// block is idle; capacity above DEPTH behaves as DEPTH.
module unordered_bag_table_core
  import ubt_pkg::*;
#(
  parameter int DEPTH      = UBT_DEPTH,
  parameter int VALUE_BITS = UBT_VALUE_BITS
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CAP_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [VAL_W-1:0]  value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [STAT_W-1:0] status_o,
  output logic [CNTF_W-1:0] count_o,
  output logic [CNTF_W-1:0] frequency_o,
  output logic              found_o,
  output logic [IDXF_W-1:0] match_index_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_ACT  = 3'd2;
  localparam logic [2:0] S_MOVE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data_q;

  logic [2:0]            state_q, state_d;
  logic [CMD_W-1:0]      cmd_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [CNT_W-1:0]      ptr_q, ptr_d;
  logic                  pend_q, pend_d;
  logic [IDX_W-1:0]      pidx_q;
  logic [CNT_W-1:0]      freq_q, freq_d;
  logic                  hit_q, hit_d;
  logic [IDX_W-1:0]      first_q, first_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CAP_W-1:0]      cap_q;

  logic [STAT_W-1:0]     res_status_q, res_status_d;
  logic [CNT_W-1:0]      res_freq_q, res_freq_d;

  logic                  out_valid_q;
  logic [STAT_W-1:0]     out_status_q;
  logic [CNTF_W-1:0]     out_count_q;
  logic [CNTF_W-1:0]     out_freq_q;
  logic                  out_found_q;
  logic [IDXF_W-1:0]     out_index_q;

  logic                  in_accept;
  logic                  out_free;
  logic                  add_ok;
  logic                  load_out;
  logic                  rd_en;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [VALUE_BITS-1:0] wr_data;
  logic [63:0]           value_ext;
  logic [CMP_W-1:0]      cnt_x, cap_x;
  logic [CNT_W+CNTF_W-1:0] cnt_wide, freq_wide;
  logic [IDX_W+IDXF_W-1:0] first_wide;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == S_DONE) && out_free;
  assign value_ext  = {32'b0, value_i};

  assign cnt_x  = CMP_W'(cnt_q);
  assign cap_x  = CMP_W'(cap_q);
  assign add_ok = (cnt_x < cap_x) && (cnt_q < CNT_W'(DEPTH));

  assign cfg_ready_o = 1'b1;

  // Entry memory: one read and one write port, registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_comb begin
    state_d      = state_q;
    ptr_d        = ptr_q;
    pend_d       = 1'b0;
    freq_d       = freq_q;
    hit_d        = hit_q;
    first_d      = first_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_freq_d   = res_freq_q;
    rd_en        = 1'b0;
    rd_addr      = ptr_q[IDX_W-1:0];
    wr_en        = 1'b0;
    wr_addr      = cnt_q[IDX_W-1:0];
    wr_data      = val_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ptr_d   = '0;
          freq_d  = '0;
          hit_d   = 1'b0;
          first_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // Compare the entry read last cycle, issue the next read.
        if (pend_q && rd_data_q == val_q) begin
          freq_d = freq_q + 1'b1;
          if (!hit_q) begin
            hit_d   = 1'b1;
            first_d = pidx_q;
          end
        end
        if (ptr_q != cnt_q) begin
          rd_en  = 1'b1;
          ptr_d  = ptr_q + 1'b1;
          pend_d = 1'b1;
        end else begin
          state_d = S_ACT;
        end
      end
      S_ACT: begin
        res_status_d = ST_OK;
        res_freq_d   = freq_q;
        state_d      = S_DONE;
        case (cmd_q)
          CMD_ADD: begin
            if (add_ok) begin
              wr_en      = 1'b1;
              cnt_d      = cnt_q + 1'b1;
              res_freq_d = freq_q + 1'b1;
            end else begin
              res_status_d = ST_FULL;
            end
          end
          CMD_REMOVE: begin
            res_freq_d = '0;
            if (cnt_q == '0) begin
              res_status_d = ST_EMPTY;
            end else if (hit_q) begin
              // Fetch the last slot to move it into the hole.
              cnt_d      = cnt_q - 1'b1;
              rd_en      = 1'b1;
              rd_addr    = cnt_d[IDX_W-1:0];
              res_freq_d = freq_q - 1'b1;
              state_d    = S_MOVE;
            end else begin
              res_status_d = ST_NOTFOUND;
            end
          end
          CMD_CLEAR: begin
            cnt_d      = '0;
            res_freq_d = '0;
          end
          default: begin
          end
        endcase
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = first_q;
        wr_data = rd_data_q;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      cap_q   <= CAP_RESET;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q <= cmd_i;
      val_q <= value_ext[VALUE_BITS-1:0];
    end
    ptr_q        <= ptr_d;
    pidx_q       <= ptr_q[IDX_W-1:0];
    freq_q       <= freq_d;
    hit_q        <= hit_d;
    first_q      <= first_d;
    res_status_q <= res_status_d;
    res_freq_q   <= res_freq_d;
  end

  assign cnt_wide   = {{CNTF_W{1'b0}}, cnt_q};
  assign freq_wide  = {{CNTF_W{1'b0}}, res_freq_q};
  assign first_wide = {{IDXF_W{1'b0}}, first_q};

  // Output register: drop on take, load when the slot frees up.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_status_q <= res_status_q;
      out_count_q  <= cnt_wide[CNTF_W-1:0];
      out_freq_q   <= freq_wide[CNTF_W-1:0];
      out_found_q  <= hit_q;
      out_index_q  <= hit_q ? first_wide[IDXF_W-1:0] : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign count_o       = out_count_q;
  assign frequency_o   = out_freq_q;
  assign found_o       = out_found_q;
  assign match_index_o = out_index_q;

  `UBT_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q == S_SCAN)
  `UBT_ASSERT_IMPL(a_move_needs_hit, state_q == S_MOVE, hit_q && cmd_q == CMD_REMOVE)
  `UBT_ASSERT_IMPL(a_result_from_done, $rose(out_valid_q), $past(state_q == S_DONE))
  `UBT_ASSERT_NEXT(a_add_grows, state_q == S_ACT && cmd_q == CMD_ADD && add_ok,
                   cnt_q == $past(cnt_q) + 1'b1)

endmodule
